@@ src/kits_pkg.sv @@
// Shared types and constants for the key-ID table search block.
// No dependencies; every other file refers to this package by scoped names.
package kits_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int ID_BYTES_DEF    = 8;

    localparam int KEY_W   = 64;
    localparam int KIND_W  = 2;
    localparam int START_W = 6;
    localparam int INDEX_W = 6;
    localparam int ERR_W   = 2;
    localparam int COUNT_W = 7;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD_PRIMARY = 2'd0,
        KIND_ADD_SUBKEY  = 2'd1,
        KIND_LOOKUP      = 2'd2,
        KIND_CLEAR       = 2'd3
    } kind_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK         = 2'd0,
        ERR_FULL       = 2'd1,
        ERR_NO_PRIMARY = 2'd2
    } err_t;

    // Scan token handed from cell to cell.
    typedef struct packed {
        logic active;
        logic found;
        logic sub;
    } tok_t;

    // Entry write strobes broadcast to the cells.
    typedef struct packed {
        logic pri;
        logic sub;
    } wr_cmd_t;

endpackage

@@ src/kits_if.sv @@
// Request and response channel interfaces for the key-ID table search block.
// Depends on kits_pkg for field widths.
interface kits_req_if;
    logic                          valid;
    logic                          ready;
    logic [kits_pkg::KIND_W-1:0]   kind;
    logic [kits_pkg::KEY_W-1:0]    key_id;
    logic [kits_pkg::START_W-1:0]  start_index;

    modport source (output valid, kind, key_id, start_index, input ready);
    modport sink   (input valid, kind, key_id, start_index, output ready);
endinterface

interface kits_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [kits_pkg::INDEX_W-1:0]  match_index;
    logic                          matched_subkey;
    logic [kits_pkg::ERR_W-1:0]    error_code;
    logic [kits_pkg::COUNT_W-1:0]  entry_count;

    modport source (output valid, found, match_index, matched_subkey, error_code,
                    entry_count, input ready);
    modport sink   (input valid, found, match_index, matched_subkey, error_code,
                    entry_count, output ready);
endinterface

@@ src/kits_cell.sv @@
// One table entry: primary and subkey ID storage plus one stage of the scan.
// Depends on kits_pkg.
module kits_cell #(
    parameter int TABLE_DEPTH = kits_pkg::TABLE_DEPTH_DEF,
    parameter int ID_BYTES    = kits_pkg::ID_BYTES_DEF,
    parameter int INDEX       = 0
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  kits_pkg::wr_cmd_t                     wr,
    input  logic [$clog2(TABLE_DEPTH)-1:0]        wr_index,
    input  logic [8*ID_BYTES-1:0]                 wr_id,
    input  logic [8*ID_BYTES-1:0]                 probe,
    input  logic [kits_pkg::START_W-1:0]          start,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]      count,
    input  kits_pkg::tok_t                        tok_in,
    input  logic [$clog2(TABLE_DEPTH)-1:0]        idx_in,
    output kits_pkg::tok_t                        tok_out,
    output logic [$clog2(TABLE_DEPTH)-1:0]        idx_out
);

    localparam int IDX_W     = $clog2(TABLE_DEPTH);
    localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W     = (CNT_W > kits_pkg::START_W) ? CNT_W : kits_pkg::START_W;
    localparam int ID_BITS   = 8 * ID_BYTES;
    localparam int HALF_BITS = 8 * (ID_BYTES / 2);
    localparam int MID_LO    = ID_BITS - 2 * HALF_BITS;
    localparam logic [CMP_W-1:0] MY_POS = CMP_W'(INDEX);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [ID_BITS-1:0] pri_reg;
    logic [ID_BITS-1:0] sub_reg;
    kits_pkg::tok_t     tok_reg, tok_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;

    logic in_range;
    logic pri_hit;
    logic sub_hit;

    // Full match, or probe's top half equal to stored half below its top.
    function automatic logic id_match(input logic [ID_BITS-1:0] stored,
                                      input logic [ID_BITS-1:0] pr);
        return (stored == pr) ||
               (stored[MID_LO +: HALF_BITS] == pr[ID_BITS-1 -: HALF_BITS]);
    endfunction

    always_comb
    begin
        in_range = (MY_POS >= CMP_W'(start)) && (MY_POS < CMP_W'(count));
        pri_hit  = id_match(pri_reg, probe);
        sub_hit  = (sub_reg != '0) && id_match(sub_reg, probe);
        tok_next = tok_in;
        idx_next = idx_in;
        if (tok_in.active && !tok_in.found && in_range && (pri_hit || sub_hit))
        begin
            tok_next.found = 1'b1;
            tok_next.sub   = !pri_hit;
            idx_next       = MY_IDX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.pri && (wr_index == MY_IDX))
        begin
            pri_reg <= wr_id;
            sub_reg <= '0;
        end
        else if (wr.sub && (wr_index == MY_IDX))
        begin
            sub_reg <= wr_id;
        end
        idx_reg <= idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;
    assign idx_out = idx_reg;

endmodule

@@ src/kits_chain.sv @@
// Row of TABLE_DEPTH entry cells; the scan token moves one cell per cycle.
// Depends on kits_pkg and kits_cell.
module kits_chain #(
    parameter int TABLE_DEPTH = kits_pkg::TABLE_DEPTH_DEF,
    parameter int ID_BYTES    = kits_pkg::ID_BYTES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  kits_pkg::wr_cmd_t                     wr,
    input  logic [$clog2(TABLE_DEPTH)-1:0]        wr_index,
    input  logic [8*ID_BYTES-1:0]                 wr_id,
    input  logic [8*ID_BYTES-1:0]                 probe,
    input  logic [kits_pkg::START_W-1:0]          start,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]      count,
    input  logic                                  inject,
    output kits_pkg::tok_t                        end_tok,
    output logic [$clog2(TABLE_DEPTH)-1:0]        end_idx
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    kits_pkg::tok_t   tok [TABLE_DEPTH+1];
    logic [IDX_W-1:0] idx [TABLE_DEPTH+1];

    assign tok[0] = '{active: inject, found: 1'b0, sub: 1'b0};
    assign idx[0] = '0;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        kits_cell #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .ID_BYTES    (ID_BYTES),
            .INDEX       (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .wr       (wr),
            .wr_index (wr_index),
            .wr_id    (wr_id),
            .probe    (probe),
            .start    (start),
            .count    (count),
            .tok_in   (tok[i]),
            .idx_in   (idx[i]),
            .tok_out  (tok[i+1]),
            .idx_out  (idx[i+1])
        );
    end

    assign end_tok = tok[TABLE_DEPTH];
    assign end_idx = idx[TABLE_DEPTH];

endmodule

@@ src/key_id_table_search_top.sv @@
// Top level of the key-ID table search block: request decode, entry count, scan control.
// Depends on kits_pkg, kits_if and kits_chain.
//
// Each table entry lives in its own cell of a row of TABLE_DEPTH cells. Add-primary,
// add-subkey and clear requests have their response registered at the edge that
// accepts the request. A lookup sends a scan token down the row, one cell per
// cycle, with the probe and start index held in registers and broadcast to every cell;
// the first cell in range whose primary ID (or non-zero subkey ID) matches marks the
// token. The token is registered in inject_reg on acceptance, passes through the token
// register of every cell, is captured in the hold registers from the output of the last
// cell, and is then registered in the response register once that is free; the token
// always runs the whole row no matter where the match sits. The next request is taken
// only in the idle state, once the response register is free or being emptied, so a
// response that the receiver does not take holds off every new request. Matching uses
// the low 8*ID_BYTES bits of key_id. There is no clearing pass after reset: entries at
// or above the entry count are never looked at.
module key_id_table_search_top #(
    parameter int TABLE_DEPTH = kits_pkg::TABLE_DEPTH_DEF,
    parameter int ID_BYTES    = kits_pkg::ID_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    kits_req_if.sink          req,
    kits_rsp_if.source        rsp
);

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int ID_BITS = 8 * ID_BYTES;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]             count_reg, count_next;
    logic                         inject_reg, inject_next;
    logic [ID_BITS-1:0]           probe_reg;
    logic [kits_pkg::START_W-1:0] start_reg;

    // held scan result while waiting for the response register
    logic                         hold_found_reg;
    logic                         hold_sub_reg;
    logic [IDX_W-1:0]             hold_idx_reg;

    // response register
    logic                         rsp_valid_reg, rsp_valid_next;
    logic                         rsp_found_reg, rsp_found_next;
    logic [kits_pkg::INDEX_W-1:0] rsp_index_reg, rsp_index_next;
    logic                         rsp_sub_reg, rsp_sub_next;
    kits_pkg::err_t               rsp_err_reg, rsp_err_next;
    logic [kits_pkg::COUNT_W-1:0] rsp_count_reg, rsp_count_next;
    logic                         rsp_load;

    logic                         out_free;
    logic                         accept;
    logic                         is_full;
    logic                         is_empty;
    logic [CNT_W-1:0]             last_pos;
    logic [IDX_W-1:0]             add_idx;
    logic [IDX_W-1:0]             last_idx;

    kits_pkg::wr_cmd_t            wr;
    logic [IDX_W-1:0]             wr_index;
    kits_pkg::tok_t               end_tok;
    logic [IDX_W-1:0]             end_idx;

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = req.valid && req.ready;

    assign is_full   = (count_reg == FULL_COUNT);
    assign is_empty  = (count_reg == '0);
    assign last_pos  = count_reg - CNT_W'(1);
    assign add_idx   = count_reg[IDX_W-1:0];
    assign last_idx  = last_pos[IDX_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        inject_next    = 1'b0;
        wr             = '0;
        wr_index       = add_idx;
        rsp_load       = 1'b0;
        rsp_found_next = 1'b0;
        rsp_index_next = '0;
        rsp_sub_next   = 1'b0;
        rsp_err_next   = kits_pkg::ERR_OK;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (kits_pkg::kind_t'(req.kind))
                        kits_pkg::KIND_ADD_PRIMARY:
                        begin
                            rsp_load = 1'b1;
                            if (is_full)
                            begin
                                rsp_err_next = kits_pkg::ERR_FULL;
                            end
                            else
                            begin
                                wr.pri         = 1'b1;
                                wr_index       = add_idx;
                                rsp_index_next = kits_pkg::INDEX_W'(add_idx);
                                count_next     = count_reg + CNT_W'(1);
                            end
                        end
                        kits_pkg::KIND_ADD_SUBKEY:
                        begin
                            rsp_load = 1'b1;
                            if (is_empty)
                            begin
                                rsp_err_next = kits_pkg::ERR_NO_PRIMARY;
                            end
                            else
                            begin
                                wr.sub         = 1'b1;
                                wr_index       = last_idx;
                                rsp_index_next = kits_pkg::INDEX_W'(last_idx);
                            end
                        end
                        kits_pkg::KIND_LOOKUP:
                        begin
                            inject_next = 1'b1;
                            state_next  = ST_SCAN;
                        end
                        kits_pkg::KIND_CLEAR:
                        begin
                            rsp_load   = 1'b1;
                            count_next = '0;
                        end
                        default:
                        begin
                            rsp_load = 1'b0;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (end_tok.active)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    rsp_load       = 1'b1;
                    rsp_found_next = hold_found_reg;
                    rsp_sub_next   = hold_sub_reg;
                    rsp_index_next = hold_found_reg ? kits_pkg::INDEX_W'(hold_idx_reg) : '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rsp_count_next = kits_pkg::COUNT_W'(count_next);
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            inject_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            inject_reg    <= inject_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            probe_reg <= req.key_id[ID_BITS-1:0];
            start_reg <= req.start_index;
        end
        if (state_reg == ST_SCAN && end_tok.active)
        begin
            hold_found_reg <= end_tok.found;
            hold_sub_reg   <= end_tok.sub;
            hold_idx_reg   <= end_idx;
        end
        if (rsp_load)
        begin
            rsp_found_reg <= rsp_found_next;
            rsp_index_reg <= rsp_index_next;
            rsp_sub_reg   <= rsp_sub_next;
            rsp_err_reg   <= rsp_err_next;
            rsp_count_reg <= rsp_count_next;
        end
    end

    kits_chain #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ID_BYTES    (ID_BYTES)
    ) u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .wr_index (wr_index),
        .wr_id    (req.key_id[ID_BITS-1:0]),
        .probe    (probe_reg),
        .start    (start_reg),
        .count    (count_reg),
        .inject   (inject_reg),
        .end_tok  (end_tok),
        .end_idx  (end_idx)
    );

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.found          = rsp_found_reg;
    assign rsp.match_index    = rsp_index_reg;
    assign rsp.matched_subkey = rsp_sub_reg;
    assign rsp.error_code     = rsp_err_reg;
    assign rsp.entry_count    = rsp_count_reg;

    // Entry count never passes the table depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count above table depth");

    // The scan token launched from inject_reg always reaches the end of the row.
    a_token_latency: assert property (@(posedge clk) disable iff (!rst_n)
        inject_reg |-> ##TABLE_DEPTH end_tok.active)
        else $error("scan token lost in the cell row");

    // A match can only name an entry that is held.
    a_match_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (end_tok.active && end_tok.found) |-> (CNT_W'(end_idx) < count_reg))
        else $error("scan matched an entry beyond the entry count");

endmodule
